/* src/lfu_pkg.sv */
// lfu_pkg: shared constants for the lfu cache table and its port checker
// fixed field widths, request codes and the capacity reset value
// no dependencies
`default_nettype none

package lfu_pkg;

    localparam int FUNC_W    = 1;
    localparam int KEY_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int CAP_W     = 5;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

/* src/lfu_cache_table.sv */
// lfu_cache_table: least-frequently-used key-value table with oldest-touch tie-break
// entries live in one synchronous memory, occupied bits and fill count in flops
// depends on lfu_pkg
//
// usage
//   requests enter on the s_ group: s_tuser holds the operation (get or put),
//   s_tdata the key and the value. a get returns one result on the m_ group:
//   m_tuser holds the hit flag, m_tdata the stored value or all ones on a miss.
//   a put returns nothing. cfg_we / cfg_wdata write the capacity register.
// timing
//   one request at a time. every request reads all entries once to find the
//   key, the eviction candidate and the first free slot; a request that
//   changes the table then reads every entry again in a second pass, writing
//   the target's new word and rewriting the other occupied entries with their
//   updated age. a get hit and a put that stores take both passes, a get miss
//   and a put at capacity zero only the first. a result shows in the same
//   cycle as the next request can be taken.
// reset and stall
//   reset empties the table (occupied bits and fill count cleared, capacity
//   16); no clearing pass is needed. a result waits in the output register;
//   the next request is taken while it waits, and a further get result holds
//   back until the register is free.
`default_nettype none

module lfu_cache_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0]      cfg_wdata,  // capacity
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lfu_pkg::S_TDATA_W-1:0]  s_tdata,    // key[15:0], value[47:16]
    input  wire logic [lfu_pkg::FUNC_W-1:0]     s_tuser,    // func[0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lfu_pkg::M_TDATA_W-1:0]       m_tdata,    // read_value[31:0]
    output logic                                m_tuser     // found[0]
);

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_BITS  = IDX_BITS;
    localparam int SWP_BITS  = IDX_BITS + 1;
    localparam int FILL_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS  = (FILL_BITS > lfu_pkg::CAP_W) ? FILL_BITS : lfu_pkg::CAP_W;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic [AGE_BITS-1:0]   age;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESULT
    } state_t;

    // entry memory
    entry_t                mem [ENTRIES];
    entry_t                rd_word;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [IDX_BITS-1:0]   mem_waddr;
    entry_t                mem_wdata;
    logic                  mem_we;

    state_t                state_reg;
    logic [lfu_pkg::CAP_W-1:0] capacity_reg;
    logic [ENTRIES-1:0]    occupied_reg;
    logic [FILL_BITS-1:0]  fill_reg;

    logic [lfu_pkg::FUNC_W-1:0] req_func_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    logic [SWP_BITS-1:0]   sweep_reg;
    logic                  rd_valid_reg;
    logic [IDX_BITS-1:0]   rd_idx_reg;

    logic                  hit_found_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic [AGE_BITS-1:0]   hit_age_reg;

    logic                  vic_have_reg;
    logic [IDX_BITS-1:0]   vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_count_reg;
    logic [AGE_BITS-1:0]   vic_age_reg;

    logic                  free_found_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;

    logic [IDX_BITS-1:0]   tgt_idx_reg;
    logic [AGE_BITS-1:0]   tgt_age_reg;
    entry_t                tgt_word_reg;
    logic                  insert_reg;
    logic                  then_result_reg;

    logic                  res_found_reg;
    logic [lfu_pkg::M_TDATA_W-1:0] res_value_reg;

    logic                  m_tvalid_reg;
    logic [lfu_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] value_in;
    logic                  issue;
    logic                  last_rd;
    logic                  occ_rd;
    logic                  better;
    logic [COUNT_BITS-1:0] hit_count_next;
    logic [AGE_BITS-1:0]   age_next;
    logic [CMP_BITS-1:0]   cap_ext;
    logic [CMP_BITS-1:0]   cap_eff;
    logic                  table_full;
    logic                  cap_zero;
    logic [lfu_pkg::M_TDATA_W-1:0] hit_value_ext;
    logic                  out_free;
    logic                  get_hit;
    logic                  put_insert;

    assign key_in   = KEY_BITS'(s_tdata[lfu_pkg::KEY_W-1:0]);
    assign value_in = VALUE_BITS'(s_tdata[lfu_pkg::KEY_W +: lfu_pkg::VALUE_W]);

    assign issue     = ((state_reg == S_SCAN) || (state_reg == S_UPDATE))
                       && (sweep_reg < SWP_BITS'(ENTRIES));
    assign mem_raddr = sweep_reg[IDX_BITS-1:0];
    assign last_rd   = rd_valid_reg && (rd_idx_reg == IDX_BITS'(ENTRIES - 1));
    assign occ_rd    = occupied_reg[rd_idx_reg];

    assign better = !vic_have_reg || (rd_word.count < vic_count_reg)
                    || ((rd_word.count == vic_count_reg) && (rd_word.age > vic_age_reg));

    assign hit_count_next = (&hit_count_reg) ? hit_count_reg
                                             : hit_count_reg + COUNT_BITS'(1);

    assign age_next = (insert_reg || (rd_word.age < tgt_age_reg))
                      ? rd_word.age + AGE_BITS'(1) : rd_word.age;

    assign cap_ext    = CMP_BITS'(capacity_reg);
    assign cap_eff    = (cap_ext > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_ext;
    assign table_full = CMP_BITS'(fill_reg) >= cap_eff;
    assign cap_zero   = (capacity_reg == '0);

    assign get_hit    = (req_func_reg == lfu_pkg::FUNC_GET) && hit_found_reg;
    assign put_insert = (req_func_reg == lfu_pkg::FUNC_PUT) && !cap_zero
                        && !hit_found_reg && !table_full;

    assign hit_value_ext = lfu_pkg::M_TDATA_W'($signed(hit_value_reg));
    assign out_free      = !m_tvalid_reg || m_tready;

    // write-back of the second pass: target gets its new word, other occupied entries get their updated age
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = rd_word;
        if ((state_reg == S_UPDATE) && rd_valid_reg)
        begin
            if (rd_idx_reg == tgt_idx_reg)
            begin
                mem_we    = 1'b1;
                mem_wdata = tgt_word_reg;
            end
            else if (occ_rd)
            begin
                mem_we        = 1'b1;
                mem_wdata.age = age_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            capacity_reg    <= lfu_pkg::CAP_RESET;
            occupied_reg    <= '0;
            fill_reg        <= '0;
            req_func_reg    <= lfu_pkg::FUNC_GET;
            req_key_reg     <= '0;
            req_value_reg   <= '0;
            sweep_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_value_reg   <= '0;
            hit_count_reg   <= '0;
            hit_age_reg     <= '0;
            vic_have_reg    <= 1'b0;
            vic_idx_reg     <= '0;
            vic_count_reg   <= '0;
            vic_age_reg     <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            tgt_idx_reg     <= '0;
            tgt_age_reg     <= '0;
            tgt_word_reg    <= '0;
            insert_reg      <= 1'b0;
            then_result_reg <= 1'b0;
            res_found_reg   <= 1'b0;
            res_value_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end

            if ((state_reg == S_RESULT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            rd_valid_reg <= issue;
            rd_idx_reg   <= sweep_reg[IDX_BITS-1:0];
            if (issue)
            begin
                sweep_reg <= sweep_reg + SWP_BITS'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_func_reg   <= s_tuser;
                        req_key_reg    <= key_in;
                        req_value_reg  <= value_in;
                        sweep_reg      <= '0;
                        hit_found_reg  <= 1'b0;
                        vic_have_reg   <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (rd_valid_reg)
                    begin
                        if (occ_rd)
                        begin
                            if (!hit_found_reg && (rd_word.key == req_key_reg))
                            begin
                                hit_found_reg <= 1'b1;
                                hit_idx_reg   <= rd_idx_reg;
                                hit_value_reg <= rd_word.value;
                                hit_count_reg <= rd_word.count;
                                hit_age_reg   <= rd_word.age;
                            end
                            if (better)
                            begin
                                vic_have_reg  <= 1'b1;
                                vic_idx_reg   <= rd_idx_reg;
                                vic_count_reg <= rd_word.count;
                                vic_age_reg   <= rd_word.age;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                    end
                    if (last_rd)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    sweep_reg          <= '0;
                    insert_reg         <= put_insert;
                    then_result_reg    <= get_hit;
                    tgt_word_reg.key   <= req_key_reg;
                    tgt_word_reg.value <= get_hit ? hit_value_reg : req_value_reg;
                    tgt_word_reg.count <= hit_found_reg ? hit_count_next : COUNT_BITS'(1);
                    tgt_word_reg.age   <= '0;
                    if (req_func_reg == lfu_pkg::FUNC_GET)
                    begin
                        if (hit_found_reg)
                        begin
                            tgt_idx_reg   <= hit_idx_reg;
                            tgt_age_reg   <= hit_age_reg;
                            res_found_reg <= 1'b1;
                            res_value_reg <= hit_value_ext;
                            state_reg     <= S_UPDATE;
                        end
                        else
                        begin
                            res_found_reg <= 1'b0;
                            res_value_reg <= '1;
                            state_reg     <= S_RESULT;
                        end
                    end
                    else if (cap_zero)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (hit_found_reg)
                    begin
                        tgt_idx_reg <= hit_idx_reg;
                        tgt_age_reg <= hit_age_reg;
                        state_reg   <= S_UPDATE;
                    end
                    else if (table_full)
                    begin
                        tgt_idx_reg <= vic_idx_reg;
                        tgt_age_reg <= vic_age_reg;
                        state_reg   <= S_UPDATE;
                    end
                    else
                    begin
                        tgt_idx_reg                <= free_idx_reg;
                        tgt_age_reg                <= '0;
                        occupied_reg[free_idx_reg] <= 1'b1;
                        fill_reg                   <= fill_reg + FILL_BITS'(1);
                        state_reg                  <= S_UPDATE;
                    end
                end

                S_UPDATE:
                begin
                    if (last_rd)
                    begin
                        state_reg <= then_result_reg ? S_RESULT : S_IDLE;
                    end
                end

                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= res_value_reg;
                        m_tuser_reg <= res_found_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* src/lfu_chk.sv */
// lfu_chk: port-level checks for the lfu cache table
// attached to lfu_cache_table by the bind at the end of this file
// depends on lfu_pkg
`default_nettype none

module lfu_chk (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lfu_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // one request at a time: ready drops after a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a result never appears the cycle after a request with the output empty
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared too early");

    // a miss always reads as all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '1))
        else $error("miss result not all ones");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
